@@ hdl/drs_pkg.sv @@
// Package for the depth record sorter: record and queue word types,
// the back-end state encoding and fixed queue sizing. No dependencies.
package drs_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_AW    = 1;

    // One stored record: head, adjusted key, tail
    typedef struct packed {
        logic [WORD_W-1:0]        head;
        logic signed [WORD_W-1:0] key;
        logic [WORD_W-1:0]        tail;
    } record_t;

    // Classified word handed from front to back
    typedef struct packed {
        record_t rec;
        logic    store;    // record fits and goes into the chain
        logic    last;     // closes the list, starts the drain
        logic    dropped;  // some record of this list was lost
    } qword_t;

    typedef enum logic {
        BK_LOAD,
        BK_DRAIN
    } back_state_t;

endpackage

@@ hdl/drs_front.sv @@
// Front end of the depth record sorter: accepts records, adjusts keys by
// arrival index and marks overflow. Depends on drs_pkg.
module drs_front #(
    parameter int unsigned MAX_RECORDS = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  logic [31:0]                 head_word,
    input  logic signed [31:0]          depth_key,
    input  logic [31:0]                 tail_word,
    input  logic                        last_in,
    input  logic                        q_full,
    output logic                        q_push,
    output drs_pkg::qword_t             q_word
);
    import drs_pkg::*;

    localparam int unsigned CW = $clog2(MAX_RECORDS + 1);

    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic          room;

    // Classify the incoming word
    always_comb
    begin
        room             = (count_reg < CW'(MAX_RECORDS));
        q_push           = push && !q_full;
        q_word.rec.head  = head_word;
        q_word.rec.key   = depth_key + WORD_W'(count_reg);
        q_word.rec.tail  = tail_word;
        q_word.store     = room;
        q_word.last      = last_in;
        q_word.dropped   = ovf_reg || !room;
        count_next       = count_reg;
        ovf_next         = ovf_reg;
        if (q_push)
        begin
            if (last_in)
            begin
                count_next = '0;
                ovf_next   = 1'b0;
            end
            else if (room)
            begin
                count_next = count_reg + CW'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    // Hold the arrival count and overflow mark
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

@@ hdl/drs_queue.sv @@
// Short queue between front and back of the depth record sorter.
// Depends on drs_pkg.
module drs_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  drs_pkg::qword_t wr_word,
    output logic            full,
    input  logic            pop,
    output logic            valid,
    output drs_pkg::qword_t rd_word
);
    import drs_pkg::*;

    localparam int unsigned LW = $clog2(Q_DEPTH + 1);

    qword_t        slot_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [LW-1:0] level_reg;
    logic          do_push, do_pop;

    always_comb
    begin
        full    = (level_reg == LW'(Q_DEPTH));
        valid   = (level_reg != '0);
        do_push = push && !full;
        do_pop  = pop && valid;
        rd_word = slot_reg[rd_ptr_reg];
    end

    // Write the incoming word
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_word;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_AW'(1);
            end
            if (do_push && !do_pop)
            begin
                level_reg <= level_reg + LW'(1);
            end
            else if (do_pop && !do_push)
            begin
                level_reg <= level_reg - LW'(1);
            end
        end
    end

endmodule

@@ hdl/drs_back.sv @@
// Back end of the depth record sorter: insertion chain that keeps records
// in descending key order, then drains them one per pop. Depends on drs_pkg.
module drs_back #(
    parameter int unsigned MAX_RECORDS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  drs_pkg::qword_t   q_word,
    output logic              q_pop,
    output logic              empty,
    input  logic              pop,
    output drs_pkg::record_t  out_rec,
    output logic              out_last,
    output logic              dropped
);
    import drs_pkg::*;

    localparam int unsigned CW = $clog2(MAX_RECORDS + 1);

    back_state_t   state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          drop_reg, drop_next;
    record_t       chain_reg  [MAX_RECORDS];
    record_t       chain_next [MAX_RECORDS];
    logic [MAX_RECORDS-1:0] goes_before;
    logic          do_insert, do_shift;

    // Per cell: does the new record go at or in front of this cell
    always_comb
    begin
        for (int i = 0; i < MAX_RECORDS; i++)
        begin
            goes_before[i] = (CW'(i) >= count_reg) ||
                             (q_word.rec.key > chain_reg[i].key);
        end
    end

    // Next contents of each cell: hold, take the new record, or shift
    for (genvar g = 0; g < MAX_RECORDS; g++)
    begin : g_cell
        if (g == 0)
        begin : g_first
            always_comb
            begin
                chain_next[g] = chain_reg[g];
                if (do_insert && goes_before[g])
                begin
                    chain_next[g] = q_word.rec;
                end
                else if (do_shift)
                begin
                    chain_next[g] = chain_reg[g+1];
                end
            end
        end
        else if (g == MAX_RECORDS - 1)
        begin : g_end
            always_comb
            begin
                chain_next[g] = chain_reg[g];
                if (do_insert && goes_before[g])
                begin
                    chain_next[g] = goes_before[g-1] ? chain_reg[g-1] : q_word.rec;
                end
            end
        end
        else
        begin : g_mid
            always_comb
            begin
                chain_next[g] = chain_reg[g];
                if (do_insert && goes_before[g])
                begin
                    chain_next[g] = goes_before[g-1] ? chain_reg[g-1] : q_word.rec;
                end
                else if (do_shift)
                begin
                    chain_next[g] = chain_reg[g+1];
                end
            end
        end
    end

    // Sequencer: load words from the queue, then drain the sorted run
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        drop_next  = drop_reg;
        q_pop      = 1'b0;
        do_insert  = 1'b0;
        do_shift   = 1'b0;
        empty      = 1'b1;
        out_rec    = chain_reg[0];
        out_last   = (count_reg == CW'(1));
        dropped    = drop_reg;
        case (state_reg)
            BK_LOAD:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    do_insert = q_word.store;
                    if (q_word.store)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    if (q_word.last)
                    begin
                        state_next = BK_DRAIN;
                        drop_next  = q_word.dropped;
                    end
                end
            end
            BK_DRAIN:
            begin
                empty = 1'b0;
                if (pop)
                begin
                    do_shift   = 1'b1;
                    count_next = count_reg - CW'(1);
                    if (count_reg == CW'(1))
                    begin
                        state_next = BK_LOAD;
                        drop_next  = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = BK_LOAD;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_LOAD;
            count_reg <= '0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            drop_reg  <= drop_next;
        end
    end

    // Advance the chain
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RECORDS; i++)
        begin
            chain_reg[i] <= chain_next[i];
        end
    end

endmodule

@@ hdl/depth_record_sort.sv @@
// Depth record sorter, top level. Input queue side: push/full with
// head_word, depth_key, tail_word, last_in; result side: empty/pop with
// out_head, out_key, out_tail, out_last, dropped.
// Each record's key is raised by its arrival index in the list (wrapping at
// 32 bits). The record with last_in closes the list; then every held record
// comes out in descending order of adjusted key, equal keys in arrival
// order, out_last on the final one, dropped set on all if the list held more
// than MAX_RECORDS records (the excess is discarded).
// Loading takes one record per cycle while the queue has room: the front
// end adjusts the key and writes a two-word queue; the insertion chain
// places one per cycle. The first result shows once the last record has
// left the queue; results then follow one per cycle as long as pop is held.
// While the run drains, input is taken until the queue is full (two words);
// full stays high until the last result is popped and the queue is read
// again. A stalled receiver simply holds the current result on the ports.
// Reset empties the queue and the chain and clears counts; nothing is
// cleared in the record storage itself.
// Depends on drs_pkg, drs_front, drs_queue, drs_back.
module depth_record_sort #(
    parameter int unsigned MAX_RECORDS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [31:0]        head_word,
    input  logic signed [31:0] depth_key,
    input  logic [31:0]        tail_word,
    input  logic               last_in,
    output logic               empty,
    input  logic               pop,
    output logic [31:0]        out_head,
    output logic signed [31:0] out_key,
    output logic [31:0]        out_tail,
    output logic               out_last,
    output logic               dropped
);
    import drs_pkg::*;

    logic    q_push, q_full, q_pop, q_valid;
    qword_t  q_in_word, q_out_word;
    record_t out_rec;

    drs_front #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .head_word (head_word),
        .depth_key (depth_key),
        .tail_word (tail_word),
        .last_in   (last_in),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_word    (q_in_word)
    );

    drs_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_word (q_in_word),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .rd_word (q_out_word)
    );

    drs_back #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_word   (q_out_word),
        .q_pop    (q_pop),
        .empty    (empty),
        .pop      (pop),
        .out_rec  (out_rec),
        .out_last (out_last),
        .dropped  (dropped)
    );

    assign full     = q_full;
    assign out_head = out_rec.head;
    assign out_key  = out_rec.key;
    assign out_tail = out_rec.tail;

endmodule

@@ hdl/drs_check.sv @@
// Port-level checks for the depth record sorter and the bind that
// attaches them to depth_record_sort. No package dependency.
module drs_check (
    input logic               clk,
    input logic               rst_n,
    input logic               empty,
    input logic               pop,
    input logic signed [31:0] out_key,
    input logic [31:0]        out_head,
    input logic               out_last,
    input logic               dropped
);

    // Nothing to deliver straight after reset
    a_reset_empty: assert property (@(posedge clk) $rose(rst_n) |-> empty)
        else $error("result shown straight after reset");

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(out_key) && $stable(out_head))
        else $error("waiting result changed");

    // Within a run keys never rise and the next word follows at once
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !empty && !out_last |=> !empty && (out_key <= $past(out_key)))
        else $error("sorted run out of order or broken");

    // Overflow mark is the same on every word of a run
    a_drop_run: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !empty && !out_last |=> dropped == $past(dropped))
        else $error("dropped changed within a run");

endmodule

bind depth_record_sort drs_check u_drs_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (empty),
    .pop      (pop),
    .out_key  (out_key),
    .out_head (out_head),
    .out_last (out_last),
    .dropped  (dropped)
);

@@ bench/depth_record_sort_tb.sv @@
// Testbench for depth_record_sort: pushes lists of records, predicts the
// sorted words with its own stable sort and checks every popped word.
// Depends on drs_pkg and the depth_record_sort RTL.
module depth_record_sort_tb;
    import drs_pkg::WORD_W;

    localparam int unsigned CAPACITY   = 64;
    localparam int unsigned RAND_WORDS = 480;
    localparam int unsigned CYCLE_CAP  = 200000;
    localparam int unsigned TAIL_WAIT  = 20;
    localparam int unsigned HOLD_LEN   = 400;
    localparam int unsigned HOLD_AFTER = 60;
    localparam int unsigned CALM_WORDS = 40;

    typedef enum {
        KEY_RANDOM,
        KEY_TIED,
        KEY_EXTREME,
        KEY_NEAR
    } key_style_t;

    typedef struct {
        logic [WORD_W-1:0]        head;
        logic signed [WORD_W-1:0] key;
        logic [WORD_W-1:0]        tail;
        logic                     fin;
    } in_word_t;

    typedef struct {
        logic [WORD_W-1:0]        head;
        logic signed [WORD_W-1:0] key;
        logic [WORD_W-1:0]        tail;
        logic                     fin;
        logic                     drop;
    } out_word_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               push      = 1'b0;
    logic               full;
    logic [31:0]        head_word = '0;
    logic signed [31:0] depth_key = '0;
    logic [31:0]        tail_word = '0;
    logic               last_in   = 1'b0;
    logic               empty;
    logic               pop       = 1'b0;
    logic [31:0]        out_head;
    logic signed [31:0] out_key;
    logic [31:0]        out_tail;
    logic               out_last;
    logic               dropped;

    in_word_t    pending_words[$];
    in_word_t    held_records[$];
    out_word_t   sorted_q[$];
    logic        list_lost = 1'b0;
    in_word_t    cur_word;
    out_word_t   want;
    int unsigned tx_gap    = 0;
    int unsigned rx_gap    = 0;
    logic        calm      = 1'b0;
    int unsigned hold_left = 0;
    logic        hold_done = 1'b0;
    int unsigned popped    = 0;
    int unsigned cycle_no  = 0;
    int          errors    = 0;

    depth_record_sort #(
        .MAX_RECORDS(CAPACITY)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .head_word(head_word),
        .depth_key(depth_key),
        .tail_word(tail_word),
        .last_in  (last_in),
        .empty    (empty),
        .pop      (pop),
        .out_head (out_head),
        .out_key  (out_key),
        .out_tail (out_tail),
        .out_last (out_last),
        .dropped  (dropped)
    );

    always #10 clk = ~clk;

    // Store one accepted record; on the closing record queue the sorted list
    task automatic load_record(input in_word_t w);
        in_word_t  r;
        in_word_t  order[$];
        out_word_t o;
        int        j;
        if (held_records.size() < CAPACITY)
        begin
            r = w;
            r.key = w.key + held_records.size();
            held_records.push_back(r);
        end
        else
        begin
            list_lost = 1'b1;
        end
        if (w.fin)
        begin
            // a later record only moves ahead of strictly smaller keys
            foreach (held_records[i])
            begin
                j = order.size();
                while (j > 0 && held_records[i].key > order[j-1].key)
                    j--;
                order.insert(j, held_records[i]);
            end
            foreach (order[i])
            begin
                o.head = order[i].head;
                o.key  = order[i].key;
                o.tail = order[i].tail;
                o.fin  = (i == order.size() - 1);
                o.drop = list_lost;
                sorted_q.push_back(o);
            end
            held_records.delete();
            list_lost = 1'b0;
        end
    endtask

    task automatic report(input string field, input logic [31:0] got, input logic [31:0] exp_v);
        $display("mismatch on %s: got %h, want %h", field, got, exp_v);
        errors++;
    endtask

    task automatic add_word(input logic [31:0] h, input logic [31:0] k, input logic [31:0] t,
                            input logic f);
        in_word_t w;
        w.head = h;
        w.key  = k;
        w.tail = t;
        w.fin  = f;
        pending_words.push_back(w);
    endtask

    // Build a list of len records with keys shaped by style
    task automatic add_list(input int len, input key_style_t style);
        logic [31:0] base;
        logic [31:0] k;
        base = $urandom;
        for (int i = 0; i < len; i++)
        begin
            case (style)
                KEY_TIED:    k = base - i;
                KEY_NEAR:    k = base + $urandom_range(0, 3) - i;
                KEY_EXTREME:
                    case ($urandom_range(0, 3))
                        0:       k = 32'h7fff_ffff;
                        1:       k = 32'h8000_0000;
                        2:       k = 32'h0000_0000;
                        default: k = 32'hffff_ffff;
                    endcase
                default:     k = $urandom;
            endcase
            add_word($urandom, k, $urandom, i == len - 1);
        end
    endtask

    // Sender: offer pending words, with bursts of idling
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                load_record(cur_word);
            calm <= (pending_words.size() < CALM_WORDS);
            if (!(push && full))
            begin
                if (tx_gap != 0)
                begin
                    tx_gap <= tx_gap - 1;
                    push   <= 1'b0;
                end
                else if (!calm && cycle_no[7] && $urandom_range(0, 7) == 0)
                begin
                    tx_gap <= $urandom_range(0, 9);
                    push   <= 1'b0;
                end
                else if (pending_words.size() != 0)
                begin
                    cur_word  = pending_words.pop_front();
                    head_word <= cur_word.head;
                    depth_key <= cur_word.key;
                    tail_word <= cur_word.tail;
                    last_in   <= cur_word.fin;
                    push      <= 1'b1;
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each popped word against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                popped <= popped + 1;
                if (sorted_q.size() == 0)
                begin
                    report("unexpected word", out_key, '0);
                end
                else
                begin
                    want = sorted_q.pop_front();
                    if (out_head !== want.head)
                        report("out_head", out_head, want.head);
                    if (out_key !== want.key)
                        report("out_key", out_key, want.key);
                    if (out_tail !== want.tail)
                        report("out_tail", out_tail, want.tail);
                    if (out_last !== want.fin)
                        report("out_last", {31'b0, out_last}, {31'b0, want.fin});
                    if (dropped !== want.drop)
                        report("dropped", {31'b0, dropped}, {31'b0, want.drop});
                end
            end
            if (hold_left != 0)
            begin
                pop <= 1'b0;
            end
            else if (rx_gap != 0)
            begin
                rx_gap <= rx_gap - 1;
                pop    <= 1'b0;
            end
            else if (!calm && cycle_no[8] && $urandom_range(0, 5) == 0)
            begin
                rx_gap <= $urandom_range(0, 9);
                pop    <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    // Hold off the receiver once during a drain so the input backs up
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && popped >= HOLD_AFTER && !empty)
        begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
    end

    // Count cycles and stop a run that hangs
    always @(posedge clk)
    begin
        cycle_no <= cycle_no + 1;
        if (cycle_no == CYCLE_CAP)
        begin
            $display("depth_record_sort_tb: errors");
            $finish;
        end
    end

    initial
    begin
        int n_rand;
        int pick;
        int len;
        // single record at the top key, extreme words
        add_word(32'h0000_0000, 32'h7fff_ffff, 32'hffff_ffff, 1'b1);
        // arrival index wraps the top key to the bottom
        add_word(32'hffff_ffff, 32'h0000_0000, 32'h0000_0000, 1'b0);
        add_word(32'h0000_0001, 32'h7fff_ffff, 32'h0000_0002, 1'b0);
        add_word(32'h0000_0002, 32'h8000_0000, 32'h0000_0003, 1'b1);
        // equal adjusted keys leave in arrival order
        for (int i = 0; i < 4; i++)
            add_word(32'h100 + i, 32'd10 - i, i, i == 3);
        // negative keys
        add_word(32'h0000_0010, 32'hffff_ffff, 32'h1234_5678, 1'b0);
        add_word(32'h0000_0011, 32'hffff_fffb, 32'h8765_4321, 1'b0);
        add_word(32'h0000_0012, 32'h0000_0003, 32'h0f0f_0f0f, 1'b0);
        add_word(32'h0000_0013, 32'h8000_0000, 32'hf0f0_f0f0, 1'b1);
        // alternating bit patterns
        add_word(32'haaaa_aaaa, 32'h5555_5555, 32'h5555_5555, 1'b0);
        add_word(32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaaa, 1'b1);

        // a list that fills the store exactly, then one that overflows it
        add_list(CAPACITY, KEY_RANDOM);
        add_list(CAPACITY + 2, KEY_NEAR);
        n_rand = 2 * CAPACITY + 2;
        while (n_rand < RAND_WORDS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 88)
                len = $urandom_range(1, 8);
            else if (pick < 94)
                len = CAPACITY;
            else
                len = $urandom_range(CAPACITY + 1, CAPACITY + 4);
            add_list(len, key_style_t'($urandom_range(0, 3)));
            n_rand += len;
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // drain everything, then allow the pipeline to settle
        while (pending_words.size() != 0 || push || sorted_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);
        if (errors == 0 && sorted_q.size() == 0)
            $display("depth_record_sort_tb: clean");
        else
            $display("depth_record_sort_tb: errors");
        $finish;
    end

endmodule
